FILE: rtl/apbct_pkg.sv
// shared types, codes and constants for the box collision table
package apbct_pkg;

  localparam int unsigned MAX_BOXES_DEF = 8;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned EXT_W = 32;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_UPDATE     = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXTENT,
    S_SCAN,
    S_SHIFT,
    S_SWEEP,
    S_EMIT
  } state_t;

  // one stored box
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [EXT_W-1:0] ex;
    logic [EXT_W-1:0] ey;
    logic [EXT_W-1:0] ez;
  } box_t;

  // controls from the sequencer into the row of cells
  typedef struct packed {
    logic load;      // write the new box into the cell at the fill point
    logic shift;     // cells at or above the gap take their upper neighbour
    logic rotate;    // whole row moves down one place, head wraps to tail
  } cell_ctl_t;

  // axis test, 2*|ca-cb| in Q.12 against ea+eb
  function automatic logic axis_hit(logic signed [COORD_W-1:0] ca,
                                    logic signed [COORD_W-1:0] cb,
                                    logic [EXT_W-1:0] ea, logic [EXT_W-1:0] eb);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0] ad;
    logic [COORD_W+13:0] lhs;
    logic [EXT_W:0] rhs;
    begin
      d = {ca[COORD_W-1], ca} - {cb[COORD_W-1], cb};
      ad = d[COORD_W] ? (~d + 1'b1) : d;
      lhs = {ad, 13'd0};
      rhs = {1'b0, ea} + {1'b0, eb};
      axis_hit = {{(EXT_W-COORD_W-13){1'b0}}, lhs} < rhs;
    end
  endfunction

endpackage

FILE: rtl/apbct_if.sv
// valid/ready channel interface with payload
interface apbct_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/all_pairs_box_collision_table_top.sv
// top level: sequencer over a row of box cells
//  channel | dir | handshake   | payload
//  in_*    | in  | valid/ready | operation, handle, centre, scale, size
//  out_*   | out | valid/ready | handles, pair_valid, last, status, entry_total
// register: one extent product per axis, one axis after another, then the result goes
// out; a full table goes straight to output. unregister: the live entries are scanned for
// the handle, compacted when it is found, then the result goes out. update: each pair is
// tested in turn and the row rotates once per outer index, then the last result goes out;
// the row rotates back to its original order. the next item is accepted only in idle.
// reset clears the sequencer and the entry count; the cells hold no reset.
// a stalled result holds the sweep until taken.
module all_pairs_box_collision_table_top #(
  parameter int unsigned MAX_BOXES = apbct_pkg::MAX_BOXES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_handle,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_y,
  input  logic signed [15:0] in_center_z,
  input  logic [15:0] in_scale_x,
  input  logic [15:0] in_scale_y,
  input  logic [15:0] in_scale_z,
  input  logic [15:0] in_size_x,
  input  logic [15:0] in_size_y,
  input  logic [15:0] in_size_z,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] out_first_handle,
  output logic [7:0] out_second_handle,
  output logic out_pair_valid,
  output logic out_last,
  output logic [1:0] out_status,
  output logic [3:0] out_entry_total
);
  localparam int unsigned IW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  apbct_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;   // outer pass and inner offset
  logic [CW-1:0] gap_r, gap_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic found_r, found_nxt;
  apbct_pkg::box_t new_r, new_nxt;
  logic [15:0] sc_r [3];
  logic [15:0] sz_r [3];
  logic [1:0] op_r;
  logic [7:0] hnd_r;

  logic ov_r, ov_nxt;
  logic [7:0] oh1_r, oh1_nxt, oh2_r, oh2_nxt;
  logic opv_r, opv_nxt, olast_r, olast_nxt;
  logic [1:0] ost_r, ost_nxt;
  // a found pair is held back until the next one turns up or the sweep ends
  logic pend_r, pend_nxt;
  logic [7:0] ph1_r, ph1_nxt, ph2_r, ph2_nxt;

  apbct_pkg::box_t boxes [MAX_BOXES];
  apbct_pkg::cell_ctl_t ctl;
  logic [31:0] prod;
  logic hit;
  logic out_free;

  genvar g;
  generate
    for (g = 0; g < MAX_BOXES; g++) begin : g_cell
      apbct_cell u_cell (
        .clk(clk), .ctl(ctl),
        .sel_load(count_r == CW'(g)),
        .at_gap(CW'(g) >= gap_r),
        .new_box(new_r),
        .upper_box(boxes[(g + 1) % MAX_BOXES]),
        .head_box(boxes[0]),
        .is_tail(count_r == CW'(g + 1)),
        .box(boxes[g])
      );
    end
  endgenerate

  // one 16x16 product per cycle for the extents
  assign prod = sc_r[ax_r] * sz_r[ax_r];

  // pair of cell 0 with cell j
  assign hit = apbct_pkg::axis_hit(boxes[0].cx, boxes[j_r[IW-1:0]].cx, boxes[0].ex,
                                   boxes[j_r[IW-1:0]].ex)
             && apbct_pkg::axis_hit(boxes[0].cy, boxes[j_r[IW-1:0]].cy, boxes[0].ey,
                                    boxes[j_r[IW-1:0]].ey)
             && apbct_pkg::axis_hit(boxes[0].cz, boxes[j_r[IW-1:0]].cz, boxes[0].ez,
                                    boxes[j_r[IW-1:0]].ez);

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == apbct_pkg::S_IDLE) && out_free;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sc_r[0] <= in_scale_x; sc_r[1] <= in_scale_y; sc_r[2] <= in_scale_z;
      sz_r[0] <= in_size_x;  sz_r[1] <= in_size_y;  sz_r[2] <= in_size_z;
      op_r <= in_operation;
      hnd_r <= in_handle;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apbct_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (apbct_pkg::op_t'(in_operation))
            apbct_pkg::OP_REGISTER: begin
              state_nxt = (count_r >= CW'(MAX_BOXES)) ? apbct_pkg::S_EMIT
                                                       : apbct_pkg::S_EXTENT;
            end
            apbct_pkg::OP_UNREGISTER: state_nxt = apbct_pkg::S_SCAN;
            apbct_pkg::OP_UPDATE: state_nxt = apbct_pkg::S_SWEEP;
            default: state_nxt = apbct_pkg::S_EMIT;
          endcase
        end
      end
      apbct_pkg::S_EXTENT: if (ax_r == 2'd2) state_nxt = apbct_pkg::S_EMIT;
      apbct_pkg::S_SCAN: begin
        if (found_r || i_r >= count_r) state_nxt = found_r ? apbct_pkg::S_SHIFT
                                                           : apbct_pkg::S_EMIT;
      end
      apbct_pkg::S_SHIFT: state_nxt = apbct_pkg::S_EMIT;
      apbct_pkg::S_SWEEP: begin
        if (out_free && (i_r + 1'b1 >= count_r || count_r < CW'(2)))
          state_nxt = apbct_pkg::S_EMIT;
      end
      apbct_pkg::S_EMIT: if (out_free) state_nxt = apbct_pkg::S_IDLE;
      default: state_nxt = apbct_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt = count_r; i_nxt = i_r; j_nxt = j_r; gap_nxt = gap_r;
    ax_nxt = ax_r; found_nxt = found_r; new_nxt = new_r;
    ov_nxt = ov_r && !out_ready;
    oh1_nxt = oh1_r; oh2_nxt = oh2_r; opv_nxt = opv_r; olast_nxt = olast_r;
    ost_nxt = ost_r;
    pend_nxt = pend_r; ph1_nxt = ph1_r; ph2_nxt = ph2_r;
    ctl = '0;
    unique case (state_r)
      apbct_pkg::S_IDLE: begin
        i_nxt = '0; j_nxt = CW'(1); ax_nxt = '0; found_nxt = 1'b0;
        new_nxt.handle = in_handle;
        new_nxt.cx = in_center_x; new_nxt.cy = in_center_y; new_nxt.cz = in_center_z;
        // a waiting result keeps its fields until it is taken
        if (in_valid && in_ready) begin
          ost_nxt = apbct_pkg::ST_OK;
          opv_nxt = 1'b0;
          pend_nxt = 1'b0;
          if (apbct_pkg::op_t'(in_operation) == apbct_pkg::OP_REGISTER
              && count_r >= CW'(MAX_BOXES))
            ost_nxt = apbct_pkg::ST_FULL;
        end
      end
      apbct_pkg::S_EXTENT: begin
        unique case (ax_r)
          2'd0: new_nxt.ex = prod;
          2'd1: new_nxt.ey = prod;
          default: new_nxt.ez = prod;
        endcase
        ax_nxt = ax_r + 2'd1;
      end
      apbct_pkg::S_SCAN: begin
        if (!found_r && i_r < count_r) begin
          if (boxes[i_r[IW-1:0]].handle == hnd_r) begin
            found_nxt = 1'b1; gap_nxt = i_r;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else if (!found_r) begin
          ost_nxt = apbct_pkg::ST_NOT_FOUND;
        end
      end
      apbct_pkg::S_SHIFT: begin
        ctl.shift = 1'b1;
        count_nxt = count_r - 1'b1;
      end
      apbct_pkg::S_SWEEP: begin
        if (out_free) begin
          if (count_r >= CW'(2) && j_r < count_r - i_r) begin
            if (hit) begin
              // the held pair goes out now, the new one waits in case it is the last
              if (pend_r) begin
                ov_nxt = 1'b1; opv_nxt = 1'b1; olast_nxt = 1'b0;
                oh1_nxt = ph1_r; oh2_nxt = ph2_r;
              end
              pend_nxt = 1'b1;
              ph1_nxt = boxes[0].handle; ph2_nxt = boxes[j_r[IW-1:0]].handle;
            end
            j_nxt = j_r + 1'b1;
          end else begin
            // head entry done: rotate it to the tail of the live part
            ctl.rotate = 1'b1;
            i_nxt = i_r + 1'b1;
            j_nxt = CW'(1);
          end
        end
      end
      apbct_pkg::S_EMIT: begin
        if (out_free) begin
          if (op_r == apbct_pkg::OP_REGISTER && ost_r == apbct_pkg::ST_OK) begin
            ctl.load = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          ov_nxt = 1'b1;
          olast_nxt = 1'b1;
          if (pend_r) begin
            opv_nxt = 1'b1; oh1_nxt = ph1_r; oh2_nxt = ph2_r;
          end else begin
            opv_nxt = 1'b0; oh1_nxt = '0; oh2_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apbct_pkg::S_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; gap_r <= gap_nxt; ax_r <= ax_nxt;
    found_r <= found_nxt; new_r <= new_nxt;
    oh1_r <= oh1_nxt; oh2_r <= oh2_nxt; opv_r <= opv_nxt; olast_r <= olast_nxt;
    ost_r <= ost_nxt;
    pend_r <= pend_nxt; ph1_r <= ph1_nxt; ph2_r <= ph2_nxt;
  end

  assign out_valid = ov_r;
  assign out_first_handle = oh1_r;
  assign out_second_handle = oh2_r;
  assign out_pair_valid = opv_r;
  assign out_last = olast_r;
  assign out_status = ost_r;
  assign out_entry_total = 4'(count_r);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BOXES)) else $error("entry count out of range");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == apbct_pkg::S_IDLE) else $error("ready outside idle");
  a_one_change: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != apbct_pkg::S_SWEEP |=> (count_r == $past(count_r)
      || count_r == $past(count_r) + 1'b1 || count_r + 1'b1 == $past(count_r)))
    else $error("count jumped");
endmodule

FILE: rtl/apbct_cell.sv
// one table slot: holds a box and hands it to its lower neighbour
module apbct_cell (
  input  logic                clk,
  input  apbct_pkg::cell_ctl_t ctl,
  input  logic                sel_load,
  input  logic                at_gap,
  input  apbct_pkg::box_t     new_box,
  input  apbct_pkg::box_t     upper_box,
  input  apbct_pkg::box_t     head_box,
  input  logic                is_tail,
  output apbct_pkg::box_t     box
);
  apbct_pkg::box_t box_r, box_nxt;

  always_comb begin
    box_nxt = box_r;
    if (ctl.load && sel_load) begin
      box_nxt = new_box;
    end else if (ctl.shift && at_gap) begin
      box_nxt = upper_box;
    end else if (ctl.rotate) begin
      box_nxt = is_tail ? head_box : upper_box;
    end
  end

  always_ff @(posedge clk) begin
    box_r <= box_nxt;
  end

  assign box = box_r;
endmodule

FILE: verif/tb_all_pairs_box_collision_table_top.sv
// testbench for the box collision table: directed and randomised box traffic, pair sweeps checked in order
`timescale 1ns / 100ps

module tb_all_pairs_box_collision_table_top;

  localparam int NBOX = apbct_pkg::MAX_BOXES_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    apbct_pkg::op_t op;
    logic [7:0] handle;
    logic signed [15:0] cx, cy, cz;
    logic [15:0] sx, sy, sz;
    logic [15:0] zx, zy, zz;
  } box_word_t;

  typedef struct packed {
    logic [7:0] first_handle;
    logic [7:0] second_handle;
    logic pair_valid;
    logic last;
    logic [1:0] status;
    logic [3:0] entry_total;
  } pair_word_t;

  localparam int IN_W = $bits(box_word_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [7:0] o_first, o_second;
  logic o_pv, o_last;
  logic [1:0] o_status;
  logic [3:0] o_total;

  apbct_if #(.payload_t(box_word_t)) in_ch ();
  apbct_if #(.payload_t(pair_word_t)) out_ch ();

  all_pairs_box_collision_table_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_operation(in_ch.data.op), .in_handle(in_ch.data.handle),
    .in_center_x(in_ch.data.cx), .in_center_y(in_ch.data.cy), .in_center_z(in_ch.data.cz),
    .in_scale_x(in_ch.data.sx), .in_scale_y(in_ch.data.sy), .in_scale_z(in_ch.data.sz),
    .in_size_x(in_ch.data.zx), .in_size_y(in_ch.data.zy), .in_size_z(in_ch.data.zz),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_first_handle(o_first),
    .out_second_handle(o_second),
    .out_pair_valid(o_pv), .out_last(o_last),
    .out_status(o_status), .out_entry_total(o_total)
  );

  assign out_ch.data = {o_first, o_second, o_pv, o_last, o_status, o_total};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the box table
  logic [7:0] tab_handle [NBOX];
  logic signed [15:0] tab_c [NBOX][3];
  logic [31:0] tab_e [NBOX][3];
  int tab_count = 0;

  box_word_t pending_q[$];
  bit drain_q[$];
  pair_word_t pair_exp_q[$];
  bit failed = 1'b0;
  bit in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;

  function automatic bit axis_overlaps(logic signed [15:0] ca, logic signed [15:0] cb,
                                       logic [31:0] ea, logic [31:0] eb);
    longint d;
    d = longint'(ca) - longint'(cb);
    if (d < 0) d = -d;
    return (d * 8192) < (longint'(ea) + longint'(eb));
  endfunction

  function automatic pair_word_t pair_word(logic [7:0] a, logic [7:0] b, bit pv, bit lst,
                                           apbct_pkg::status_t st);
    pair_word_t r;
    r.first_handle = a;
    r.second_handle = b;
    r.pair_valid = pv;
    r.last = lst;
    r.status = st;
    r.entry_total = tab_count[3:0];
    return r;
  endfunction

  function automatic void expect_word(pair_word_t p);
    pair_exp_q.insert(pair_exp_q.size(), p);
  endfunction

  // apply one accepted word to the shadow table and queue its results
  task automatic predict_box_op(box_word_t w);
    int idx;
    int hits;
    bit hit;
    hits = 0;
    case (w.op)
      apbct_pkg::OP_REGISTER: begin
        if (tab_count >= NBOX) begin
          expect_word(pair_word(8'd0, 8'd0, 1'b0, 1'b1, apbct_pkg::ST_FULL));
        end else begin
          tab_handle[tab_count] = w.handle;
          tab_c[tab_count][0] = w.cx;
          tab_c[tab_count][1] = w.cy;
          tab_c[tab_count][2] = w.cz;
          tab_e[tab_count][0] = 32'(w.sx) * 32'(w.zx);
          tab_e[tab_count][1] = 32'(w.sy) * 32'(w.zy);
          tab_e[tab_count][2] = 32'(w.sz) * 32'(w.zz);
          tab_count++;
          expect_word(pair_word(8'd0, 8'd0, 1'b0, 1'b1, apbct_pkg::ST_OK));
        end
      end
      apbct_pkg::OP_UNREGISTER: begin
        idx = 0;
        while (idx < tab_count && tab_handle[idx] != w.handle) idx++;
        if (idx >= tab_count) begin
          expect_word(pair_word(8'd0, 8'd0, 1'b0, 1'b1, apbct_pkg::ST_NOT_FOUND));
        end else begin
          for (int k = idx; k + 1 < tab_count; k++) begin
            tab_handle[k] = tab_handle[k+1];
            tab_c[k] = tab_c[k+1];
            tab_e[k] = tab_e[k+1];
          end
          tab_count--;
          expect_word(pair_word(8'd0, 8'd0, 1'b0, 1'b1, apbct_pkg::ST_OK));
        end
      end
      apbct_pkg::OP_UPDATE: begin
        for (int i = 0; i < tab_count; i++) begin
          for (int j = i + 1; j < tab_count; j++) begin
            hit = 1'b1;
            for (int a = 0; a < 3; a++)
              if (!axis_overlaps(tab_c[i][a], tab_c[j][a], tab_e[i][a], tab_e[j][a]))
                hit = 1'b0;
            if (hit) begin
              expect_word(pair_word(tab_handle[i], tab_handle[j], 1'b1, 1'b0,
                                    apbct_pkg::ST_OK));
              hits++;
            end
          end
        end
        if (hits == 0) expect_word(pair_word(8'd0, 8'd0, 1'b0, 1'b1, apbct_pkg::ST_OK));
        else pair_exp_q[$].last = 1'b1;
      end
      default: expect_word(pair_word(8'd0, 8'd0, 1'b0, 1'b1, apbct_pkg::ST_OK));
    endcase
  endtask

  function automatic box_word_t box_word(apbct_pkg::op_t op, logic [7:0] h,
                                         logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                                         logic [15:0] s, logic [15:0] z);
    box_word_t w;
    w.op = op;
    w.handle = h;
    w.cx = cx; w.cy = cy; w.cz = cz;
    w.sx = s; w.sy = s; w.sz = s;
    w.zx = z; w.zy = z; w.zz = z;
    return w;
  endfunction

  task automatic queue_word(box_word_t w, bit drain);
    pending_q.insert(pending_q.size(), w);
    drain_q.insert(drain_q.size(), drain);
  endtask

  // input driver, changes on the falling edge
  always @(negedge clk) begin
    bit nv;
    nv = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && !in_taken) begin
        nv = 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
      end else if (pending_q.size() > 0 && !(drain_q[0] && pair_exp_q.size() > 0)) begin
        in_ch.data <= pending_q.pop_front();
        void'(drain_q.pop_front());
        nv = 1'b1;
        in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end
      in_taken = 1'b0;
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
    in_ch.valid <= nv;
  end

  // accept, predict and check on the rising edge
  always @(posedge clk) begin
    pair_word_t want;
    if (rst_n) begin
      idle_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        predict_box_op(in_ch.data);
        in_taken = 1'b1;
        idle_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (pair_exp_q.size() == 0) begin
          $error("unexpected result word %p", out_ch.data);
          failed = 1'b1;
        end else begin
          want = pair_exp_q.pop_front();
          if (out_ch.data.first_handle !== want.first_handle) begin
            $error("first_handle expected %0d got %0d", want.first_handle,
                   out_ch.data.first_handle);
            failed = 1'b1;
          end
          if (out_ch.data.second_handle !== want.second_handle) begin
            $error("second_handle expected %0d got %0d", want.second_handle,
                   out_ch.data.second_handle);
            failed = 1'b1;
          end
          if (out_ch.data.pair_valid !== want.pair_valid) begin
            $error("pair_valid expected %0d got %0d", want.pair_valid, out_ch.data.pair_valid);
            failed = 1'b1;
          end
          if (out_ch.data.last !== want.last) begin
            $error("last expected %0d got %0d", want.last, out_ch.data.last);
            failed = 1'b1;
          end
          if (out_ch.data.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_ch.data.status);
            failed = 1'b1;
          end
          if (out_ch.data.entry_total !== want.entry_total) begin
            $error("entry_total expected %0d got %0d", want.entry_total,
                   out_ch.data.entry_total);
            failed = 1'b1;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] h;
    int r;
    box_word_t w;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;

    // directed: empty table cases, unused code, field extremes, full table
    queue_word(box_word(apbct_pkg::OP_UPDATE, 8'd0, '0, '0, '0, '0, '0), 1'b0);
    queue_word(box_word(apbct_pkg::OP_UNREGISTER, 8'd7, '0, '0, '0, '0, '0), 1'b0);
    queue_word(box_word(apbct_pkg::OP_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF), 1'b0);
    queue_word(box_word(apbct_pkg::OP_REGISTER, 8'hFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                        16'hFFFF, 16'hFFFF), 1'b0);
    queue_word(box_word(apbct_pkg::OP_REGISTER, 8'h00, 16'h8000, 16'h7FFF, 16'h8000,
                        16'hFFFF, 16'hFFFF), 1'b0);
    queue_word(box_word(apbct_pkg::OP_REGISTER, 8'h11, '0, '0, '0, 16'h0000, 16'hFFFF),
               1'b0);
    queue_word(box_word(apbct_pkg::OP_UPDATE, 8'd0, '0, '0, '0, '0, '0), 1'b0);
    for (int k = 0; k < 5; k++)
      queue_word(box_word(apbct_pkg::OP_REGISTER, 8'(k + 1), 16'(k), '0, '0, 16'h0100,
                          16'h0100), 1'b0);
    queue_word(box_word(apbct_pkg::OP_REGISTER, 8'h42, '0, '0, '0, 16'h0100, 16'h0100),
               1'b0);
    queue_word(box_word(apbct_pkg::OP_UPDATE, 8'd0, '0, '0, '0, '0, '0), 1'b1);
    queue_word(box_word(apbct_pkg::OP_UNREGISTER, 8'h11, '0, '0, '0, '0, '0), 1'b0);
    queue_word(box_word(apbct_pkg::OP_UNREGISTER, 8'hFF, '0, '0, '0, '0, '0), 1'b0);
    queue_word(box_word(apbct_pkg::OP_UNREGISTER, 8'h00, '0, '0, '0, '0, '0), 1'b0);
    // duplicate handle, only the first copy goes
    for (int k = 0; k < 3; k++)
      queue_word(box_word(apbct_pkg::OP_REGISTER, 8'h03, 16'(8 * k), '0, '0, 16'h0200,
                          16'h0100), 1'b0);
    queue_word(box_word(apbct_pkg::OP_UPDATE, 8'd0, '0, '0, '0, '0, '0), 1'b0);
    queue_word(box_word(apbct_pkg::OP_UNREGISTER, 8'h03, '0, '0, '0, '0, '0), 1'b0);
    queue_word(box_word(apbct_pkg::OP_UPDATE, 8'd0, '0, '0, '0, '0, '0), 1'b1);

    // random traffic, mostly small clustered boxes from a small handle pool
    for (int n = 0; n < 460; n++) begin
      r = $urandom_range(0, 99);
      h = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
      if (r < 42) begin
        w.op = apbct_pkg::OP_REGISTER;
        w.handle = h;
        if ($urandom_range(0, 4) == 0) begin
          {w.cx, w.cy, w.cz} = 48'({$urandom, $urandom});
          {w.sx, w.sy, w.sz, w.zx, w.zy, w.zz} = {$urandom, $urandom, $urandom};
        end else begin
          w.cx = 16'($signed($urandom_range(0, 128)) - 64);
          w.cy = 16'($signed($urandom_range(0, 128)) - 64);
          w.cz = 16'($signed($urandom_range(0, 128)) - 64);
          w.sx = 16'($urandom_range(64, 1024));
          w.sy = 16'($urandom_range(64, 1024));
          w.sz = 16'($urandom_range(64, 1024));
          w.zx = 16'($urandom_range(0, 2048));
          w.zy = 16'($urandom_range(0, 2048));
          w.zz = 16'($urandom_range(0, 2048));
        end
      end else begin
        w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        w.handle = h;
        if (r < 67) w.op = apbct_pkg::OP_UNREGISTER;
        else if (r < 95) w.op = apbct_pkg::OP_UPDATE;
        else w.op = apbct_pkg::OP_NONE;
      end
      queue_word(w, $urandom_range(0, 49) == 0);
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() > 0 || in_ch.valid || pair_exp_q.size() > 0);
    repeat (100) @(posedge clk);
    if (!failed && pair_exp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: all_pairs_box_collision_table_top.f
rtl/apbct_pkg.sv
rtl/apbct_if.sv
rtl/apbct_cell.sv
rtl/all_pairs_box_collision_table_top.sv
verif/tb_all_pairs_box_collision_table_top.sv
